// File: src/lams_pkg.sv
// shared types and constants for the labeled adjacency matrix store
`timescale 1ns / 1ps

package lams_pkg;

   // number of vertex slots and the width of a slot index
   localparam int VERTICES = 8;
   localparam int SLOT_W   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int LABEL_W  = 16;
   localparam int CMD_W    = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_V   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_V   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_ARC = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_ARC = 3'd4;

   // status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef logic [LABEL_W-1:0]  label_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [VERTICES-1:0] row_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      label_type        label_a;
      label_type        label_b;
   } req_type;

   typedef struct packed {
      logic status;
      logic found;
   } rsp_type;

endpackage

// File: src/labeled_adjacency_matrix_store.sv
// labeled directed graph store with an adjacency bit matrix and a serial label scan
`timescale 1ns / 1ps
// a vertex command scans each slot for label_a in ST_SCAN_A, then updates in ST_APPLY; an arc
// command also scans label_b in ST_SCAN_B; one shared label comparator visits one slot a cycle
// busy stays high through the scan and the update, so no new command is taken until the last one
// is applied; the receiver cannot stall, each registered result shows for one cycle
// reset: synchronous, clears every slot label to free and every arc bit, no clearing pass
module labeled_adjacency_matrix_store
   import lams_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN_A = 4'b0010,
      ST_SCAN_B = 4'b0100,
      ST_APPLY  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   slot_type  idx_ff, idx_in;
   req_type   cmd_ff, cmd_in;
   logic      hit_a_ff, hit_a_in;
   logic      hit_b_ff, hit_b_in;
   slot_type  slot_a_ff, slot_a_in;
   slot_type  slot_b_ff, slot_b_in;
   logic      free_ok_ff, free_ok_in;
   slot_type  free_slot_ff, free_slot_in;
   label_type labels_ff [VERTICES];
   label_type labels_in [VERTICES];
   row_type   rows_ff [VERTICES];
   row_type   rows_in [VERTICES];
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   label_type key;
   label_type cur_label;
   logic      match;
   logic      slot_free;
   logic      last_slot;

   // shared comparator: current slot against the label being looked up
   assign key       = (state_ff == ST_SCAN_B) ? cmd_ff.label_b : cmd_ff.label_a;
   assign cur_label = labels_ff[idx_ff];
   assign match     = (cur_label == key) && (key != '0);
   assign slot_free = (cur_label == '0);
   assign last_slot = (idx_ff == SLOT_W'(VERTICES - 1));

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // sequencer, scan bookkeeping and store updates
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      hit_a_in     = hit_a_ff;
      hit_b_in     = hit_b_ff;
      slot_a_in    = slot_a_ff;
      slot_b_in    = slot_b_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      labels_in    = labels_ff;
      rows_in      = rows_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_data;
               idx_in     = '0;
               hit_a_in   = 1'b0;
               hit_b_in   = 1'b0;
               free_ok_in = 1'b0;
               state_in   = ST_SCAN_A;
            end
         end
         ST_SCAN_A: begin
            if (match) begin
               hit_a_in  = 1'b1;
               slot_a_in = idx_ff;
            end
            if (slot_free && !free_ok_ff) begin
               free_ok_in   = 1'b1;
               free_slot_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_slot) begin
               idx_in = '0;
               if (cmd_ff.cmd == CMD_ADD_ARC || cmd_ff.cmd == CMD_DEL_ARC) begin
                  state_in = ST_SCAN_B;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_SCAN_B: begin
            if (match) begin
               hit_b_in  = 1'b1;
               slot_b_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_slot) begin
               idx_in   = '0;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            rsp_valid_in = 1'b1;
            rsp_in.found = 1'b0;
            state_in     = ST_IDLE;
            unique case (cmd_ff.cmd)
               CMD_SEARCH: begin
                  rsp_in.status = STATUS_DONE;
                  rsp_in.found  = hit_a_ff;
               end
               CMD_ADD_V: begin
                  if (hit_a_ff || !free_ok_ff || cmd_ff.label_a == '0) begin
                     rsp_in.status = STATUS_REJECTED;
                  end else begin
                     rsp_in.status           = STATUS_DONE;
                     labels_in[free_slot_ff] = cmd_ff.label_a;
                  end
               end
               CMD_DEL_V: begin
                  if (!hit_a_ff) begin
                     rsp_in.status = STATUS_REJECTED;
                  end else begin
                     rsp_in.status        = STATUS_DONE;
                     labels_in[slot_a_ff] = '0;
                     rows_in[slot_a_ff]   = '0;
                     // drop the column in every row
                     for (int k = 0; k < VERTICES; k++) begin
                        rows_in[k][slot_a_ff] = 1'b0;
                     end
                  end
               end
               CMD_ADD_ARC, CMD_DEL_ARC: begin
                  // equal labels land in the same slot, so this also rejects self loops
                  if (!hit_a_ff || !hit_b_ff || slot_a_ff == slot_b_ff) begin
                     rsp_in.status = STATUS_REJECTED;
                  end else begin
                     rsp_in.status = STATUS_DONE;
                     rows_in[slot_a_ff][slot_b_ff] = (cmd_ff.cmd == CMD_ADD_ARC);
                  end
               end
               default: begin
                  rsp_in.status = STATUS_REJECTED;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // graph store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VERTICES; i++) begin
            labels_ff[i] <= '0;
            rows_ff[i]   <= '0;
         end
      end else begin
         labels_ff <= labels_in;
         rows_ff   <= rows_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      hit_a_ff     <= hit_a_in;
      hit_b_ff     <= hit_b_in;
      slot_a_ff    <= slot_a_in;
      slot_b_ff    <= slot_b_in;
      free_ok_ff   <= free_ok_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
   end

   // a result strobe follows only the update cycle
   a_strobe_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_APPLY))
      else $error("result strobe without a preceding update cycle");

   // an accepted command starts the first scan
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN_A))
      else $error("accepted command did not start the scan");

   // a found search is never rejected
   a_found_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> (rsp_ff.status == STATUS_DONE))
      else $error("found result carries rejected status");

   // only arc commands scan for the destination label
   a_scan_b_only_arcs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_B) |->
         (cmd_ff.cmd == CMD_ADD_ARC || cmd_ff.cmd == CMD_DEL_ARC))
      else $error("destination scan for a vertex command");

endmodule
